/* rtl/ihc_pkg.sv */
// types and constants of the ipv4 header checker
// used by ipv4_header_checker_core; no dependencies
`default_nettype none

package ihc_pkg;

  typedef struct packed {
    logic [15:0] header_word;
    logic        first_word;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [1:0]  protocol_class;
    logic [7:0]  protocol_number;
    logic [31:0] remote_address;
    logic [5:0]  header_bytes;
    logic [15:0] payload_length;
  } out_item_t;

  // verdict codes
  localparam logic [2:0] VERDICT_ACCEPT   = 3'd0;
  localparam logic [2:0] VERDICT_NOT_MINE = 3'd1;
  localparam logic [2:0] VERDICT_CHECKSUM = 3'd2;
  localparam logic [2:0] VERDICT_VERSION  = 3'd3;
  localparam logic [2:0] VERDICT_FRAG     = 3'd4;

  // protocol classes
  localparam logic [1:0] CLASS_ICMP  = 2'd0;
  localparam logic [1:0] CLASS_UDP   = 2'd1;
  localparam logic [1:0] CLASS_TCP   = 2'd2;
  localparam logic [1:0] CLASS_OTHER = 2'd3;

  // raw protocol numbers
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] PROTO_TCP  = 8'd6;

  // register indexes
  localparam logic REG_LOCAL_ADDRESS   = 1'b0;
  localparam logic REG_PROTOCOL_ENABLE = 1'b1;

  localparam logic [15:0] FRAG_MASK      = 16'h3FFF;
  localparam logic [15:0] SUM_GOOD       = 16'hFFFF;
  localparam logic [3:0]  IP_VERSION     = 4'h4;
  localparam logic [5:0]  MIN_WORDS      = 6'd10;
  localparam logic [2:0]  PROTO_EN_RESET = 3'b111;

endpackage

`default_nettype wire

/* rtl/ipv4_header_checker_core.sv */
// ipv4 header checker: running ones' complement sum and one verdict per header
// depends on ihc_pkg for the request types and codes
//
// channel  direction  handshake          payload
// in       in         in_valid/in_stall  ihc_pkg::in_item_t (one header word)
// out      out        out_valid/out_stall ihc_pkg::out_item_t (one verdict)
// cfg      in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// one word is taken every cycle unless in_stall is high; a word passes an input
// register and is then folded into the header state, its verdict leaving from
// the result register.
// the 17-bit end-around add of the checksum sets the cycle budget.
// rst is synchronous; a stalled result holds the input register, which stalls
// the input only while it is full.
`default_nettype none

module ipv4_header_checker_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire ihc_pkg::in_item_t  in_data,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      ihc_pkg::out_item_t out_data,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [31:0]        cfg_data
);

  import ihc_pkg::*;

  // configuration
  logic [31:0] local_address;
  logic [2:0]  protocol_enable;

  // input register
  logic        s1_valid;
  in_item_t    s1;

  // header state
  logic [5:0]  word_count;
  logic [15:0] sum_acc;
  logic [3:0]  header_ihl;
  logic [3:0]  header_version;
  logic [15:0] datagram_length;
  logic        fragment_seen;
  logic [7:0]  protocol_seen;
  logic [31:0] source_seen;
  logic [31:0] destination_seen;
  logic        header_done;

  logic [5:0]  word_count_next;
  logic [15:0] sum_acc_next;
  logic [3:0]  header_ihl_next;
  logic [3:0]  header_version_next;
  logic [15:0] datagram_length_next;
  logic        fragment_seen_next;
  logic [7:0]  protocol_seen_next;
  logic [31:0] source_seen_next;
  logic [31:0] destination_seen_next;

  logic        advance;
  logic        active;
  logic        fire;
  logic        done;
  logic [5:0]  k;
  logic [4:0]  hwords;
  logic [5:0]  need;
  logic [16:0] sum_wide;
  logic [5:0]  hbytes;
  out_item_t   result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_address   <= '0;
      protocol_enable <= PROTO_EN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LOCAL_ADDRESS:   local_address   <= cfg_data;
        REG_PROTOCOL_ENABLE: protocol_enable <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // input register moves on whenever the result slot is free or being taken
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || advance) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1 <= in_data;
    end
  end

  assign active = s1.first_word || !header_done;
  assign fire   = s1_valid && advance && active;
  assign k      = s1.first_word ? '0 : word_count;

  always_comb begin
    // a first word starts from a cleared header
    if (s1.first_word) begin
      sum_acc_next          = '0;
      header_ihl_next       = '0;
      header_version_next   = '0;
      datagram_length_next  = '0;
      fragment_seen_next    = 1'b0;
      protocol_seen_next    = '0;
      source_seen_next      = '0;
      destination_seen_next = '0;
    end else begin
      sum_acc_next          = sum_acc;
      header_ihl_next       = header_ihl;
      header_version_next   = header_version;
      datagram_length_next  = datagram_length;
      fragment_seen_next    = fragment_seen;
      protocol_seen_next    = protocol_seen;
      source_seen_next      = source_seen;
      destination_seen_next = destination_seen;
    end

    case (k)
      6'd0: begin
        header_version_next = s1.header_word[15:12];
        header_ihl_next     = s1.header_word[11:8];
      end
      6'd1: datagram_length_next       = s1.header_word;
      6'd3: fragment_seen_next         = (s1.header_word & FRAG_MASK) != '0;
      6'd4: protocol_seen_next         = s1.header_word[7:0];
      6'd6: source_seen_next[31:16]    = s1.header_word;
      6'd7: source_seen_next[15:0]     = s1.header_word;
      6'd8: destination_seen_next[31:16] = s1.header_word;
      6'd9: destination_seen_next[15:0]  = s1.header_word;
      default: ;
    endcase

    hwords = {header_ihl_next, 1'b0};
    // end-around carry; the sum of two 16-bit words never carries twice
    sum_wide = {1'b0, sum_acc_next} + {1'b0, s1.header_word};
    if (k < {1'b0, hwords}) begin
      sum_acc_next = sum_wide[15:0] + {15'd0, sum_wide[16]};
    end

    word_count_next = k + 6'd1;
    need = ({1'b0, hwords} > MIN_WORDS) ? {1'b0, hwords} : MIN_WORDS;
    done = (word_count_next == need);
  end

  always_comb begin
    hbytes = {header_ihl_next, 2'b00};

    if (destination_seen_next != local_address) begin
      result.verdict = VERDICT_NOT_MINE;
    end else if (sum_acc_next != SUM_GOOD) begin
      result.verdict = VERDICT_CHECKSUM;
    end else if (header_version_next != IP_VERSION) begin
      result.verdict = VERDICT_VERSION;
    end else if (fragment_seen_next) begin
      result.verdict = VERDICT_FRAG;
    end else begin
      result.verdict = VERDICT_ACCEPT;
    end

    if (protocol_seen_next == PROTO_ICMP && protocol_enable[0]) begin
      result.protocol_class = CLASS_ICMP;
    end else if (protocol_seen_next == PROTO_UDP && protocol_enable[1]) begin
      result.protocol_class = CLASS_UDP;
    end else if (protocol_seen_next == PROTO_TCP && protocol_enable[2]) begin
      result.protocol_class = CLASS_TCP;
    end else begin
      result.protocol_class = CLASS_OTHER;
    end

    result.protocol_number = protocol_seen_next;
    result.remote_address  = source_seen_next;
    result.header_bytes    = hbytes;
    result.payload_length  = (datagram_length_next >= {10'd0, hbytes}) ?
                             datagram_length_next - {10'd0, hbytes} : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_done <= 1'b1;
      word_count  <= '0;
    end else if (fire) begin
      header_done <= done;
      word_count  <= word_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      sum_acc          <= sum_acc_next;
      header_ihl       <= header_ihl_next;
      header_version   <= header_version_next;
      datagram_length  <= datagram_length_next;
      fragment_seen    <= fragment_seen_next;
      protocol_seen    <= protocol_seen_next;
      source_seen      <= source_seen_next;
      destination_seen <= destination_seen_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (out_valid && out_stall) || (fire && done);
    end
  end

  always_ff @(posedge clk) begin
    if (fire && done) begin
      out_data <= result;
    end
  end

`ifndef SYNTHESIS
  // the input only stalls behind a full input register
  a_stall_needs_s1: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty input register");

  // a header in progress never runs past the longest header
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    !header_done |-> (word_count < 6'd30))
    else $error("word count ran past the longest header");

  // a verdict always closes its header
  a_done_after_result: assert property (@(posedge clk) disable iff (rst)
    (fire && done) |=> (header_done && out_valid))
    else $error("verdict issued without closing the header");

  // only defined verdict codes leave the block
  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.verdict <= VERDICT_FRAG))
    else $error("undefined verdict code");
`endif

endmodule

`default_nettype wire
